// ===== design/jdcm_pkg.sv =====
package jdcm_pkg;

   localparam int ADC_MAX    = 1023;
   localparam int ADC_CENTER = 512;
   localparam int MAX_SQ     = ADC_MAX * ADC_MAX;
   localparam int DZ_RESET   = 20;

   localparam int DIV_STEPS  = 10;
   localparam int CIRC_STEPS = 15;
   localparam int MAG_STEPS  = 10;

   localparam int AXIS_LAT  = DIV_STEPS + 2;
   localparam int CIRC_LAT  = CIRC_STEPS + 2;
   localparam int MAG_PAD   = CIRC_LAT - (MAG_STEPS + 2);
   localparam int TOTAL_LAT = AXIS_LAT + CIRC_LAT + 2;

   typedef struct packed {
      logic [9:0] x_raw;
      logic [9:0] y_raw;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] x_circle;
      logic signed [15:0] y_circle;
      logic        [9:0]  magnitude;
   } rsp_item_type;

endpackage

// ===== design/joystick_deadzone_circle_map_core.sv =====
// Joystick dead zone and circle mapping. One pair of raw samples is taken in every
// cycle that start is high; busy is always low, so items may follow back to back.
// Each item's result is on rsp_item with rsp_strobe high for one cycle, in order of
// acceptance; the path runs through the 10-step per-axis divider and the 15-step
// bit-serial search that maps the vector into the unit disc. The receiver cannot
// stall: a result must be captured in the one cycle that it is shown.
// Write csr_write_data to set the dead zone half width only while no item is
// in flight; it resets to 20.
module joystick_deadzone_circle_map_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  jdcm_pkg::req_item_type req_item,
   output logic                   rsp_strobe,
   output jdcm_pkg::rsp_item_type rsp_item,
   input  logic                   csr_write_en,
   input  logic [8:0]             csr_write_data
);

   localparam int LAT = jdcm_pkg::TOTAL_LAT;

   logic [8:0] dz_ff;
   logic [8:0] dz_in;
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;
   logic accept;

   logic signed [10:0] px;
   logic signed [10:0] py;
   logic [9:0]  ax;
   logic [9:0]  ay;
   logic [19:0] sqx;
   logic [19:0] sqy;
   logic [20:0] s_in;

   logic [20:0] s_ff;
   logic [20:0] seff_ff;
   logic [9:0]  ax_ff;
   logic [9:0]  ay_ff;
   logic        nx_ff;
   logic        ny_ff;

   logic signed [15:0] xc;
   logic signed [15:0] yc;
   logic [9:0]  mag;
   jdcm_pkg::rsp_item_type rsp_ff;
   jdcm_pkg::rsp_item_type rsp_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign dz_in  = csr_write_en ? csr_write_data : dz_ff;
   assign vld_in = {vld_ff[LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff  <= 9'(jdcm_pkg::DZ_RESET);
         vld_ff <= '0;
      end else begin
         dz_ff  <= dz_in;
         vld_ff <= vld_in;
      end
   end

   jdcm_axis_lane u_axis_x (
      .clock(clock), .sample(req_item.x_raw), .half_width(dz_ff), .centered(px)
   );

   jdcm_axis_lane u_axis_y (
      .clock(clock), .sample(req_item.y_raw), .half_width(dz_ff), .centered(py)
   );

   always_comb begin
      ax   = px[10] ? 10'(-px) : px[9:0];
      ay   = py[10] ? 10'(-py) : py[9:0];
      sqx  = ax * ax;
      sqy  = ay * ay;
      s_in = 21'(sqx) + 21'(sqy);
   end

   // short vectors scale by ADC_MAX, long ones by their own length
   always_ff @(posedge clock) begin
      s_ff    <= s_in;
      seff_ff <= (s_in > 21'(jdcm_pkg::MAX_SQ)) ? s_in : 21'(jdcm_pkg::MAX_SQ);
      ax_ff   <= ax;
      ay_ff   <= ay;
      nx_ff   <= px[10];
      ny_ff   <= py[10];
   end

   jdcm_circle_lane u_circ_x (
      .clock(clock), .axis_abs(ax_ff), .axis_neg(nx_ff), .len_sq(seff_ff), .coord(xc)
   );

   jdcm_circle_lane u_circ_y (
      .clock(clock), .axis_abs(ay_ff), .axis_neg(ny_ff), .len_sq(seff_ff), .coord(yc)
   );

   jdcm_mag_lane u_mag (
      .clock(clock), .len_sq(s_ff), .magnitude(mag)
   );

   always_comb begin
      rsp_in.x_circle  = xc;
      rsp_in.y_circle  = yc;
      rsp_in.magnitude = mag;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = vld_ff[LAT-1];
   assign rsp_item   = rsp_ff;

`ifndef SYNTH
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(jdcm_pkg::TOTAL_LAT) rsp_strobe)
      else $error("item result missing at fixed latency");

   a_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_item.magnitude == 10'd0) ==
                      (rsp_item.x_circle == 16'sd0 && rsp_item.y_circle == 16'sd0)))
      else $error("magnitude and coordinates disagree on origin");

   a_disc: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.x_circle >= -16'sd16384 && rsp_item.x_circle <= 16'sd16384
                   && rsp_item.y_circle >= -16'sd16384 && rsp_item.y_circle <= 16'sd16384))
      else $error("coordinate outside unit disc");
`endif

endmodule

// ===== design/jdcm_axis_lane.sv =====
module jdcm_axis_lane (
   input  logic               clock,
   input  logic [9:0]         sample,
   input  logic [8:0]         half_width,
   output logic signed [10:0] centered
);

   localparam int STEPS = jdcm_pkg::DIV_STEPS;

   logic [9:0]  upper_edge;
   logic [9:0]  lower_edge;
   logic        is_upper;
   logic        is_lower;
   logic [8:0]  span_up;
   logic [18:0] num_in;
   logic [9:0]  den_in;
   logic        direct_in;
   logic [9:0]  dval_in;

   logic [18:0] rem_ff [0:STEPS];
   logic [9:0]  den_ff [0:STEPS];
   logic [9:0]  quo_ff [0:STEPS];
   logic        up_ff  [0:STEPS];
   logic        dir_ff [0:STEPS];
   logic [9:0]  dval_ff [0:STEPS];

   logic [9:0]  level;
   logic [10:0] twice;
   logic signed [10:0] centered_in;
   logic signed [10:0] centered_ff;

   always_comb begin
      upper_edge = 10'(jdcm_pkg::ADC_CENTER) + {1'b0, half_width};
      lower_edge = 10'(jdcm_pkg::ADC_CENTER) - {1'b0, half_width};
      is_upper   = sample >= upper_edge;
      is_lower   = sample <= lower_edge;
      span_up    = 9'(sample - upper_edge);
      direct_in  = 1'b0;
      dval_in    = 10'(jdcm_pkg::ADC_CENTER);
      num_in     = '0;
      den_in     = 10'd1;
      if (is_upper) begin
         // span times 511, over the remaining upper range
         num_in = {1'b0, span_up, 9'd0} - 19'(span_up);
         den_in = 10'(10'd511 - {1'b0, half_width});
         if (half_width == 9'd511) begin
            direct_in = 1'b1;
            dval_in   = 10'(jdcm_pkg::ADC_MAX);
         end
      end else if (is_lower) begin
         num_in = {sample, 9'd0};
         den_in = lower_edge;
      end else begin
         direct_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= num_in;
      den_ff[0]  <= den_in;
      quo_ff[0]  <= '0;
      up_ff[0]   <= is_upper;
      dir_ff[0]  <= direct_in;
      dval_ff[0] <= dval_in;
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_div
      localparam int K = STEPS - 1 - i;
      logic [18:0] trial;
      assign trial = 19'(den_ff[i]) << K;
      always_ff @(posedge clock) begin
         den_ff[i+1]  <= den_ff[i];
         up_ff[i+1]   <= up_ff[i];
         dir_ff[i+1]  <= dir_ff[i];
         dval_ff[i+1] <= dval_ff[i];
         if (rem_ff[i] >= trial) begin
            rem_ff[i+1] <= rem_ff[i] - trial;
            quo_ff[i+1] <= quo_ff[i] | (10'd1 << K);
         end else begin
            rem_ff[i+1] <= rem_ff[i];
            quo_ff[i+1] <= quo_ff[i];
         end
      end
   end

   always_comb begin
      if (dir_ff[STEPS]) begin
         level = dval_ff[STEPS];
      end else if (up_ff[STEPS]) begin
         level = quo_ff[STEPS] + 10'(jdcm_pkg::ADC_CENTER);
      end else begin
         level = quo_ff[STEPS];
      end
      twice = {level, 1'b0};
      if (level == 10'(jdcm_pkg::ADC_CENTER)) begin
         centered_in = '0;
      end else begin
         centered_in = signed'(11'(twice - 11'(jdcm_pkg::ADC_MAX)));
      end
   end

   always_ff @(posedge clock) begin
      centered_ff <= centered_in;
   end

   assign centered = centered_ff;

endmodule

// ===== design/jdcm_circle_lane.sv =====
module jdcm_circle_lane (
   input  logic               clock,
   input  logic [9:0]         axis_abs,
   input  logic               axis_neg,
   input  logic [20:0]        len_sq,
   output logic signed [15:0] coord
);

   localparam int STEPS = jdcm_pkg::CIRC_STEPS;
   localparam int EW = 48;
   localparam int FW = 36;
   localparam int XW = 53;

   logic [19:0] abs_sq;

   logic [EW-1:0]    e_ff   [0:STEPS];
   logic [FW-1:0]    f_ff   [0:STEPS];
   logic [STEPS-1:0] t_ff   [0:STEPS];
   logic [20:0]      s_ff   [0:STEPS];
   logic [EW-1:0]    rhs_ff [0:STEPS];
   logic             neg_ff [0:STEPS];

   logic signed [15:0] coord_in;
   logic signed [15:0] coord_ff;

   assign abs_sq = axis_abs * axis_abs;

   always_ff @(posedge clock) begin
      e_ff[0]   <= '0;
      f_ff[0]   <= '0;
      t_ff[0]   <= '0;
      s_ff[0]   <= len_sq;
      rhs_ff[0] <= {abs_sq, 28'd0};
      neg_ff[0] <= axis_neg;
   end

   // grow t one bit a stage, tracking t*t*s and t*s
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam int K = STEPS - 1 - i;
      logic [XW-1:0] cand;
      assign cand = XW'(e_ff[i]) + (XW'(f_ff[i]) << (K + 1))
                  + (XW'(s_ff[i]) << (2 * K));
      always_ff @(posedge clock) begin
         s_ff[i+1]   <= s_ff[i];
         rhs_ff[i+1] <= rhs_ff[i];
         neg_ff[i+1] <= neg_ff[i];
         if (cand <= XW'(rhs_ff[i])) begin
            e_ff[i+1] <= EW'(cand);
            f_ff[i+1] <= FW'(f_ff[i] + (FW'(s_ff[i]) << K));
            t_ff[i+1] <= t_ff[i] | (STEPS'(1) << K);
         end else begin
            e_ff[i+1] <= e_ff[i];
            f_ff[i+1] <= f_ff[i];
            t_ff[i+1] <= t_ff[i];
         end
      end
   end

   always_comb begin
      if (neg_ff[STEPS]) begin
         coord_in = signed'(16'(-{1'b0, t_ff[STEPS]}));
      end else begin
         coord_in = signed'({1'b0, t_ff[STEPS]});
      end
   end

   always_ff @(posedge clock) begin
      coord_ff <= coord_in;
   end

   assign coord = coord_ff;

endmodule

// ===== design/jdcm_mag_lane.sv =====
module jdcm_mag_lane (
   input  logic        clock,
   input  logic [20:0] len_sq,
   output logic [9:0]  magnitude
);

   localparam int STEPS = jdcm_pkg::MAG_STEPS;
   localparam int PAD   = jdcm_pkg::MAG_PAD;

   logic [20:0] s_ff   [0:STEPS];
   logic        sat_ff [0:STEPS];
   logic [9:0]  r_ff   [0:STEPS];
   logic [19:0] e_ff   [0:STEPS];
   logic [9:0]  mag_ff [0:PAD];

   always_ff @(posedge clock) begin
      s_ff[0]   <= len_sq;
      sat_ff[0] <= len_sq >= 21'(jdcm_pkg::MAX_SQ);
      r_ff[0]   <= '0;
      e_ff[0]   <= '0;
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_root
      localparam int K = STEPS - 1 - i;
      logic [21:0] cand;
      assign cand = 22'(e_ff[i]) + (22'(r_ff[i]) << (K + 1)) + (22'(1) << (2 * K));
      always_ff @(posedge clock) begin
         s_ff[i+1]   <= s_ff[i];
         sat_ff[i+1] <= sat_ff[i];
         if (cand <= 22'(s_ff[i])) begin
            r_ff[i+1] <= r_ff[i] | (10'd1 << K);
            e_ff[i+1] <= 20'(cand);
         end else begin
            r_ff[i+1] <= r_ff[i];
            e_ff[i+1] <= e_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff[0] <= sat_ff[STEPS] ? 10'(jdcm_pkg::ADC_MAX) : r_ff[STEPS];
   end

   // delay to line up with the circle lanes
   for (genvar j = 0; j < PAD; j++) begin : g_pad
      always_ff @(posedge clock) begin
         mag_ff[j+1] <= mag_ff[j];
      end
   end

   assign magnitude = mag_ff[PAD];

endmodule

// ===== verif/joystick_deadzone_circle_map_core_tb.sv =====
module joystick_deadzone_circle_map_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 480;
   localparam int Q_ONE        = 16384;

   typedef struct {
      logic [9:0]             x_raw;
      logic [9:0]             y_raw;
      bit                     typed;
      jdcm_pkg::rsp_item_type result;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   jdcm_pkg::req_item_type req_item;
   logic                   rsp_strobe;
   jdcm_pkg::rsp_item_type rsp_item;
   logic                   csr_write_en;
   logic [8:0]             csr_write_data;

   jdcm_pkg::rsp_item_type circle_queue[$];
   logic [8:0]   dead_zone_width;
   int           error_count;
   int           cycle_count;
   int           idle_percent;

   stim_row_type directed_rows[] = '{
      '{10'd512, 10'd512, 1'b1, '{16'sd0, 16'sd0, 10'd0}},
      '{10'd0, 10'd0, 1'b1, '{-16'sd11585, -16'sd11585, 10'd1023}},
      '{10'd1023, 10'd1023, 1'b1, '{16'sd11585, 16'sd11585, 10'd1023}},
      '{10'd1023, 10'd512, 1'b1, '{16'sd16384, 16'sd0, 10'd1023}},
      '{10'd0, 10'd512, 1'b1, '{-16'sd16384, 16'sd0, 10'd1023}},
      '{10'd512, 10'd1023, 1'b1, '{16'sd0, 16'sd16384, 10'd1023}},
      '{10'd512, 10'd0, 1'b1, '{16'sd0, -16'sd16384, 10'd1023}},
      '{10'd0, 10'd1023, 1'b1, '{-16'sd11585, 16'sd11585, 10'd1023}},
      '{10'd532, 10'd512, 1'b0, '0},
      '{10'd531, 10'd493, 1'b0, '0},
      '{10'd492, 10'd512, 1'b0, '0},
      '{10'd491, 10'd533, 1'b0, '0},
      '{10'd533, 10'd491, 1'b0, '0},
      '{10'd1, 10'd1022, 1'b0, '0},
      '{10'd700, 10'd300, 1'b0, '0},
      '{10'd900, 10'd900, 1'b0, '0},
      '{10'd600, 10'd620, 1'b0, '0},
      '{10'd341, 10'd682, 1'b0, '0},
      '{10'd1000, 10'd100, 1'b0, '0},
      '{10'd511, 10'd513, 1'b0, '0}
   };

   joystick_deadzone_circle_map_core DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic longint apply_dead_zone(longint v, longint b);
      longint c = jdcm_pkg::ADC_CENTER;
      longint m = jdcm_pkg::ADC_MAX;
      if (v >= c + b) begin
         if (m - (c + b) == 0) return m;
         return (v - (c + b)) * (m - c) / (m - (c + b)) + c;
      end
      if (v <= c - b) begin
         if (c - b == 0) return 0;
         return v * c / (c - b);
      end
      return c;
   endfunction

   function automatic longint axis_numerator(longint a);
      if (a == jdcm_pkg::ADC_CENTER) return 0;
      if (a < 0) a = 0;
      if (a > jdcm_pkg::ADC_MAX) a = jdcm_pkg::ADC_MAX;
      return 2 * a - jdcm_pkg::ADC_MAX;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned s);
      longint unsigned r = 0;
      longint unsigned cand;
      for (int i = 20; i >= 0; i--) begin
         cand = r | (64'd1 << i);
         if (cand * cand <= s) r = cand;
      end
      return r;
   endfunction

   // largest t with t*t*s <= 2^28*p*p, signed like p
   function automatic longint project_to_circle(longint p, longint unsigned s);
      longint unsigned ap = (p < 0) ? -p : p;
      longint unsigned rhs = (ap * ap) << 28;
      longint unsigned t = 0;
      longint unsigned cand;
      for (int i = 14; i >= 0; i--) begin
         cand = t | (64'd1 << i);
         if (cand * cand * s <= rhs) t = cand;
      end
      return (p < 0) ? -longint'(t) : longint'(t);
   endfunction

   function automatic jdcm_pkg::rsp_item_type map_to_circle(logic [9:0] xr, logic [9:0] yr,
                                                            logic [8:0] dz);
      longint p = axis_numerator(apply_dead_zone(xr, dz));
      longint q = axis_numerator(apply_dead_zone(yr, dz));
      longint unsigned s = p * p + q * q;
      longint unsigned mm = longint'(jdcm_pkg::ADC_MAX) * jdcm_pkg::ADC_MAX;
      longint xc, yc;
      longint unsigned mag;
      jdcm_pkg::rsp_item_type r;
      if (s <= mm) begin
         xc = p * Q_ONE / jdcm_pkg::ADC_MAX;
         yc = q * Q_ONE / jdcm_pkg::ADC_MAX;
      end else begin
         xc = project_to_circle(p, s);
         yc = project_to_circle(q, s);
      end
      mag = (s >= mm) ? jdcm_pkg::ADC_MAX : floor_sqrt(s);
      r.x_circle  = xc[15:0];
      r.y_circle  = yc[15:0];
      r.magnitude = mag[9:0];
      return r;
   endfunction

   task automatic send_item(logic [9:0] xr, logic [9:0] yr, bit typed,
                            jdcm_pkg::rsp_item_type result);
      start <= 1'b1;
      req_item <= '{x_raw: xr, y_raw: yr};
      do @(posedge clock); while (busy);
      circle_queue.push_back(typed ? result : map_to_circle(xr, yr, dead_zone_width));
      if ($urandom_range(99) < idle_percent) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_percent);
      end
   endtask

   task automatic write_dead_zone(logic [8:0] value);
      start <= 1'b0;
      while (circle_queue.size() != 0) @(posedge clock);
      repeat (jdcm_pkg::TOTAL_LAT + 4) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      dead_zone_width = value;
   endtask

   task automatic send_random_item();
      logic [9:0] xr, yr;
      int kind = $urandom_range(99);
      xr = 10'($urandom_range(1023));
      yr = 10'($urandom_range(1023));
      if (kind < 25) begin
         // hover around the neutral band edges
         xr = 10'(jdcm_pkg::ADC_CENTER + int'(dead_zone_width) - 3
                  + int'($urandom_range(6)));
         if ($urandom_range(1))
            xr = 10'(jdcm_pkg::ADC_CENTER - int'(dead_zone_width) - 3
                     + int'($urandom_range(6)));
      end else if (kind < 40) begin
         xr = $urandom_range(1) ? 10'(10'd1023 - $urandom_range(3))
                                : 10'(0 + $urandom_range(3));
         yr = $urandom_range(1) ? 10'(10'd1023 - $urandom_range(3))
                                : 10'(0 + $urandom_range(3));
      end
      send_item(xr, yr, 1'b0, '0);
   endtask

   always @(posedge clock) begin
      jdcm_pkg::rsp_item_type want;
      if (!reset && rsp_strobe) begin
         if (circle_queue.size() == 0) begin
            $error("unexpected result x_circle %0d y_circle %0d magnitude %0d",
                   rsp_item.x_circle, rsp_item.y_circle, rsp_item.magnitude);
            error_count++;
         end else begin
            want = circle_queue.pop_front();
            if (rsp_item.x_circle !== want.x_circle) begin
               $error("x_circle expected %0d got %0d", want.x_circle, rsp_item.x_circle);
               error_count++;
            end
            if (rsp_item.y_circle !== want.y_circle) begin
               $error("y_circle expected %0d got %0d", want.y_circle, rsp_item.y_circle);
               error_count++;
            end
            if (rsp_item.magnitude !== want.magnitude) begin
               $error("magnitude expected %0d got %0d", want.magnitude, rsp_item.magnitude);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL joystick_deadzone_circle_map_core");
         $finish;
      end
   end

   initial begin
      logic [8:0] phase_widths[4];
      int phase_idle[4];
      idle_percent = 0;
      dead_zone_width = 9'(jdcm_pkg::DZ_RESET);
      reset <= 1'b1;
      start <= 1'b0;
      req_item <= '0;
      csr_write_en <= 1'b0;
      csr_write_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].x_raw, directed_rows[i].y_raw,
                   directed_rows[i].typed, directed_rows[i].result);

      phase_widths = '{9'd0, 9'd511, 9'($urandom_range(511)), 9'($urandom_range(40))};
      phase_idle = '{0, 72, 0, 20};
      for (int ph = 0; ph < 4; ph++) begin
         write_dead_zone(phase_widths[ph]);
         idle_percent = phase_idle[ph];
         for (int n = 0; n < RANDOM_ITEMS; n++) send_random_item();
      end

      start <= 1'b0;
      while (circle_queue.size() != 0) @(posedge clock);
      repeat (jdcm_pkg::TOTAL_LAT + 5) @(posedge clock);
      if (error_count == 0)
         $display("PASS joystick_deadzone_circle_map_core");
      else
         $display("FAIL joystick_deadzone_circle_map_core");
      $finish;
   end

endmodule

// ===== sim.f =====
design/jdcm_pkg.sv
design/jdcm_axis_lane.sv
design/jdcm_circle_lane.sv
design/jdcm_mag_lane.sv
design/joystick_deadzone_circle_map_core.sv
verif/joystick_deadzone_circle_map_core_tb.sv
